// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/core/gpe_pkg.sv =====
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types, constants and helpers of the population engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package gpe_pkg;
    localparam int MAX_GENES = 32;
    localparam int MAX_POP   = 32;
    localparam int WORD_W    = 32;
    localparam int IDX_W     = $clog2(MAX_POP);
    localparam int CNT_W     = 6;

    localparam logic [1:0] REQ_LOAD   = 2'd0;
    localparam logic [1:0] REQ_PAIR   = 2'd1;
    localparam logic [1:0] REQ_MUTATE = 2'd2;

    localparam logic REG_GENES = 1'b0;
    localparam logic REG_POP   = 1'b1;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_PAIR,
        CELL_FLIP,
        CELL_SORT,
        CELL_ROT
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic [IDX_W-1:0]   sel_a;
        logic [IDX_W-1:0]   sel_b;
        logic [CNT_W-1:0]   pop;
        logic               phase;
        logic [WORD_W-1:0]  data;
        logic [WORD_W-1:0]  mask;
        logic [WORD_W-1:0]  va;
        logic [WORD_W-1:0]  vb;
    } t_cell_ctrl;

    // n low ones, saturating at a full word
    function automatic logic [WORD_W-1:0] ones(input logic [CNT_W-1:0] n);
        logic [WORD_W-1:0] r;
        if (n >= CNT_W'(WORD_W)) r = '1;
        else r = (WORD_W'(1) << n) - WORD_W'(1);
        return r;
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/gpe_cell.sv =====
// ----------------------------------------------------------------------------
// gpe_cell
// One population slot: load, crossover, flip, odd-even sort step, rotate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module gpe_cell (
    input  wire logic                       i_clk,
    input  wire logic [gpe_pkg::IDX_W-1:0]  i_index,
    input  wire gpe_pkg::t_cell_ctrl        i_ctrl,
    input  wire logic [gpe_pkg::WORD_W-1:0] i_prev,
    input  wire logic [gpe_pkg::WORD_W-1:0] i_next,
    output logic      [gpe_pkg::WORD_W-1:0] o_value
);
    import gpe_pkg::*;

    logic [WORD_W-1:0] r_value;
    logic [WORD_W-1:0] n_value;
    logic [CNT_W-1:0]  w_k;

    assign w_k = {1'b0, i_index};

    // next value by broadcast operation
    always_comb begin
        n_value = r_value;
        case (i_ctrl.op)
            CELL_LOAD: if (i_index == i_ctrl.sel_a) n_value = i_ctrl.data;
            CELL_PAIR: begin
                if (i_index == i_ctrl.sel_a)
                    n_value = (r_value & ~i_ctrl.mask) | (i_ctrl.vb & i_ctrl.mask);
                else if (i_index == i_ctrl.sel_b)
                    n_value = (r_value & ~i_ctrl.mask) | (i_ctrl.va & i_ctrl.mask);
            end
            // only slots inside the active population flip
            CELL_FLIP: if (w_k < i_ctrl.pop) n_value = r_value ^ i_ctrl.mask;
            CELL_SORT: begin
                // lower member of a pair keeps the min, upper the max
                if (i_index[0] == i_ctrl.phase && (w_k + CNT_W'(1)) < i_ctrl.pop) begin
                    if (r_value > i_next) n_value = i_next;
                end else if (i_index[0] != i_ctrl.phase && w_k != '0 && w_k < i_ctrl.pop) begin
                    if (i_prev > r_value) n_value = i_prev;
                end
            end
            CELL_ROT: begin
                if (w_k < i_ctrl.pop)
                    n_value = (w_k == i_ctrl.pop - CNT_W'(1)) ? i_ctrl.data : i_next;
            end
            default: n_value = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;
endmodule
`default_nettype wire

// ===== rtl/core/genetic_population_engine.sv =====
// ----------------------------------------------------------------------------
// genetic_population_engine
// Population store as a row of cells with crossover, mutation and sorting.
// ----------------------------------------------------------------------------
// Input channel (i_in_valid / o_in_ready) takes one request per transaction.
// Loads and crossover pairs emit nothing, except the load that fills the
// population. That load, and every mutate request on a full population,
// starts an odd-even transposition sort across the cell row: population_size
// passes, then, after a mutate, a step that takes the sorted head as best. The
// population is then emitted on the output channel (o_out_valid /
// i_out_ready), cell 0 first, rotating the row one step per transaction, then
// the best chromosome with o_is_best and o_last high. While results are
// pending, o_in_ready stays low; a stall on the output just holds the row.
// Reset clears the control state, the load count and the best; the cells
// themselves need no clear. Configuration goes through the APB port at
// byte 0 (gene_count) and byte 4 (population_size), with pready always high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module genetic_population_engine (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [2:0]                 paddr,
    input  wire logic [31:0]                pwdata,
    output logic      [31:0]                prdata,
    output logic                            pready,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [1:0]                 i_req_type,
    input  wire logic [31:0]                i_chromosome_bits,
    input  wire logic [5:0]                 i_first_index,
    input  wire logic [5:0]                 i_second_index,
    input  wire logic [5:0]                 i_cross_start,
    input  wire logic [5:0]                 i_cross_stop,
    input  wire logic [5:0]                 i_mutate_position,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [31:0]                o_result_bits,
    output logic                            o_is_best,
    output logic                            o_last
);
    import gpe_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SORT = 3'b010,
        ST_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_load_count, n_load_count;
    logic [WORD_W-1:0] r_best, n_best;
    logic              r_best_valid, n_best_valid;
    logic              r_gen_end, n_gen_end;
    logic [CNT_W-1:0]  r_gene_count, r_pop_size;

    logic [CNT_W-1:0]  w_g, w_p, w_pos;
    logic [WORD_W-1:0] w_load_val;
    logic              w_pair_ok, w_in_acc, w_out_acc, w_full, w_emit_best;
    t_cell_ctrl        w_ctrl;
    logic [WORD_W-1:0] w_cell [MAX_POP];

    // clamped configuration
    always_comb begin
        w_g = r_gene_count;
        if (w_g < CNT_W'(1)) w_g = CNT_W'(1);
        if (w_g > CNT_W'(MAX_GENES)) w_g = CNT_W'(MAX_GENES);
        w_p = r_pop_size;
        if (w_p < CNT_W'(2)) w_p = CNT_W'(2);
        if (w_p > CNT_W'(MAX_POP)) w_p = CNT_W'(MAX_POP);
    end

    // APB register file
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gene_count <= CNT_W'(32);
            r_pop_size   <= CNT_W'(32);
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_GENES) r_gene_count <= pwdata[CNT_W-1:0];
            else                       r_pop_size   <= pwdata[CNT_W-1:0];
        end
    end
    assign prdata = (paddr[2] == REG_GENES) ? {26'd0, r_gene_count} : {26'd0, r_pop_size};

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_full      = r_load_count >= w_p;
    assign w_load_val  = i_chromosome_bits & ones(w_g);
    assign w_pos       = (i_mutate_position == '0) ? CNT_W'(1) : i_mutate_position;
    assign w_emit_best = r_cnt >= w_p;
    assign w_pair_ok   = i_first_index != i_second_index
                      && i_first_index >= CNT_W'(1) && i_second_index >= CNT_W'(1)
                      && i_first_index <= w_p && i_second_index <= w_p
                      && i_cross_start >= CNT_W'(1) && i_cross_start <= i_cross_stop
                      && i_cross_stop <= w_g;

    // sequencer and cell broadcast
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_load_count = r_load_count;
        n_best       = r_best;
        n_best_valid = r_best_valid;
        n_gen_end    = r_gen_end;
        w_ctrl       = '0;
        w_ctrl.op    = CELL_HOLD;
        w_ctrl.pop   = w_p;
        w_ctrl.phase = r_cnt[0];
        w_ctrl.sel_a = i_first_index[IDX_W-1:0] - IDX_W'(1);
        w_ctrl.sel_b = i_second_index[IDX_W-1:0] - IDX_W'(1);
        w_ctrl.va    = w_cell[w_ctrl.sel_a];
        w_ctrl.vb    = w_cell[w_ctrl.sel_b];
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_req_type)
                        REQ_LOAD: if (!w_full) begin
                            w_ctrl.op    = CELL_LOAD;
                            w_ctrl.sel_a = r_load_count[IDX_W-1:0];
                            w_ctrl.data  = w_load_val;
                            n_load_count = r_load_count + CNT_W'(1);
                            if (!r_best_valid || w_load_val < r_best) begin
                                n_best       = w_load_val;
                                n_best_valid = 1'b1;
                            end
                            if (n_load_count >= w_p) begin
                                n_state   = ST_SORT;
                                n_cnt     = '0;
                                n_gen_end = 1'b0;
                            end
                        end
                        REQ_PAIR: if (w_full && w_pair_ok) begin
                            w_ctrl.op   = CELL_PAIR;
                            w_ctrl.mask = ones(w_g - i_cross_start + CNT_W'(1))
                                        & ~ones(w_g - i_cross_stop);
                        end
                        REQ_MUTATE: if (w_full) begin
                            w_ctrl.op   = CELL_FLIP;
                            w_ctrl.mask = (w_pos <= w_g) ? (WORD_W'(1) << (w_g - w_pos)) : '0;
                            n_state     = ST_SORT;
                            n_cnt       = '0;
                            n_gen_end   = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SORT: begin
                if (r_cnt < w_p) begin
                    w_ctrl.op = CELL_SORT;
                    n_cnt     = r_cnt + CNT_W'(1);
                end else begin
                    // only a mutate generation takes the sorted head as best
                    if (r_gen_end && (!r_best_valid || w_cell[0] < r_best)) begin
                        n_best       = w_cell[0];
                        n_best_valid = 1'b1;
                    end
                    n_state = ST_EMIT;
                    n_cnt   = '0;
                end
            end
            ST_EMIT: begin
                if (w_out_acc) begin
                    if (w_emit_best) begin
                        n_state = ST_IDLE;
                    end else begin
                        w_ctrl.op   = CELL_ROT;
                        w_ctrl.data = w_cell[0];
                        n_cnt       = r_cnt + CNT_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_cnt        <= '0;
            r_load_count <= '0;
            r_best       <= '0;
            r_best_valid <= 1'b0;
            r_gen_end    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cnt        <= n_cnt;
            r_load_count <= n_load_count;
            r_best       <= n_best;
            r_best_valid <= n_best_valid;
            r_gen_end    <= n_gen_end;
        end
    end

    // cell row
    for (genvar k = 0; k < MAX_POP; k++) begin : g_cell
        logic [WORD_W-1:0] w_prev, w_next;
        assign w_prev = (k == 0) ? w_cell[0] : w_cell[(k == 0) ? 0 : k - 1];
        assign w_next = w_cell[(k + 1) % MAX_POP];
        gpe_cell u_cell (
            .i_clk   (i_clk),
            .i_index (IDX_W'(k)),
            .i_ctrl  (w_ctrl),
            .i_prev  (w_prev),
            .i_next  (w_next),
            .o_value (w_cell[k])
        );
    end

    assign o_in_ready    = (r_state == ST_IDLE);
    assign o_out_valid   = (r_state == ST_EMIT);
    assign o_result_bits = w_emit_best ? r_best : w_cell[0];
    assign o_is_best     = w_emit_best;
    assign o_last        = w_emit_best;

    `ASSERT_NEVER(a_busy_excl, i_clk, i_rst_n, o_out_valid && o_in_ready, "in ready while emitting")
    `ASSERT_CLK(a_last_best, i_clk, i_rst_n, o_out_valid && o_last |-> o_is_best && r_best_valid, "last without best")
    `ASSERT_CLK(a_last_done, i_clk, i_rst_n, w_out_acc && o_last |=> !o_out_valid && o_in_ready, "emit after last")
endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for genetic_population_engine: directed cases, a
// register change mid-run and randomized generations under varied idling.
// Each result is checked against a population model kept in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
    import gpe_pkg::*;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_GENES = 3'd0;
    localparam logic [2:0] ADDR_POP   = 3'd4;
    localparam int         SETTLE_CYCLES = 8;

    typedef struct {
        logic [1:0]  req;
        logic [31:0] bits;
        logic [5:0]  idx_a;
        logic [5:0]  idx_b;
        logic [5:0]  seg_start;
        logic [5:0]  seg_stop;
        logic [5:0]  flip_pos;
    } t_request;

    typedef struct {
        logic [31:0] bits;
        logic        best;
        logic        last;
    } t_chrom_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_req_type = '0;
    logic [31:0] i_chromosome_bits = '0;
    logic [5:0]  i_first_index = '0, i_second_index = '0;
    logic [5:0]  i_cross_start = '0, i_cross_stop = '0, i_mutate_position = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_result_bits;
    logic        o_is_best;
    logic        o_last;

    // population model
    logic [31:0]   pop_store [MAX_POP];
    int unsigned   load_count = 0;
    logic [31:0]   best_bits = '0;
    bit            best_valid = 0;
    logic [5:0]    genes_reg = 6'd32;
    logic [5:0]    pop_reg = 6'd32;
    t_chrom_result expected_chroms [$];

    int errors = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    genetic_population_engine u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_req_type(i_req_type), .i_chromosome_bits(i_chromosome_bits),
        .i_first_index(i_first_index), .i_second_index(i_second_index),
        .i_cross_start(i_cross_start), .i_cross_stop(i_cross_stop),
        .i_mutate_position(i_mutate_position),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_bits(o_result_bits), .o_is_best(o_is_best), .o_last(o_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    initial begin
        #4_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    function automatic int unsigned used_genes();
        if (genes_reg < 1) return 1;
        if (genes_reg > MAX_GENES) return MAX_GENES;
        return genes_reg;
    endfunction

    function automatic int unsigned used_pop();
        if (pop_reg < 2) return 2;
        if (pop_reg > MAX_POP) return MAX_POP;
        return pop_reg;
    endfunction

    function automatic logic [31:0] low_ones(int unsigned n);
        logic [63:0] w;
        w = (64'd1 << n) - 64'd1;
        return w[31:0];
    endfunction

    // stable insertion sort, ascending
    function automatic void sort_pop(int unsigned p);
        logic [31:0] v;
        int j;
        for (int i = 1; i < p; i++) begin
            v = pop_store[i];
            j = i;
            while (j > 0 && pop_store[j-1] > v) begin
                pop_store[j] = pop_store[j-1];
                j--;
            end
            pop_store[j] = v;
        end
    endfunction

    function automatic void queue_generation(int unsigned p);
        t_chrom_result r;
        for (int k = 0; k < p; k++) begin
            r.bits = pop_store[k]; r.best = 1'b0; r.last = 1'b0;
            expected_chroms.push_back(r);
        end
        r.bits = best_bits; r.best = 1'b1; r.last = 1'b1;
        expected_chroms.push_back(r);
    endfunction

    // apply one accepted request to the model
    function automatic void evolve_population(t_request rq);
        int unsigned g, p, a, b, s, e, pos;
        logic [31:0] v, m, x, y;
        g = used_genes();
        p = used_pop();
        if (rq.req == REQ_LOAD) begin
            if (load_count >= p) return;
            v = rq.bits & low_ones(g);
            pop_store[load_count] = v;
            load_count++;
            if (!best_valid || v < best_bits) begin
                best_bits = v;
                best_valid = 1;
            end
            if (load_count < p) return;
            sort_pop(p);
            queue_generation(p);
            return;
        end
        if (load_count < p) return;
        if (rq.req == REQ_PAIR) begin
            a = rq.idx_a; b = rq.idx_b; s = rq.seg_start; e = rq.seg_stop;
            if (a == b || a < 1 || b < 1 || a > p || b > p) return;
            if (s < 1 || s > e || e > g) return;
            m = low_ones(e - s + 1) << (g - e);
            x = pop_store[a-1];
            y = pop_store[b-1];
            pop_store[a-1] = (x & ~m) | (y & m);
            pop_store[b-1] = (y & ~m) | (x & m);
        end else if (rq.req == REQ_MUTATE) begin
            pos = rq.flip_pos;
            if (pos == 0) pos = 1;
            if (pos <= g)
                for (int k = 0; k < p; k++) pop_store[k] ^= (32'd1 << (g - pos));
            sort_pop(p);
            if (!best_valid || pop_store[0] < best_bits) begin
                best_bits = pop_store[0];
                best_valid = 1;
            end
            queue_generation(p);
        end
    endfunction

    // result checker and receiver stalls
    always @(posedge i_clk) begin
        t_chrom_result want;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (expected_chroms.size() == 0) begin
                    $display("%0t: unexpected transaction, got bits %h best %b last %b",
                             $time, o_result_bits, o_is_best, o_last);
                    errors++;
                end else begin
                    want = expected_chroms.pop_front();
                    if (o_result_bits !== want.bits) begin
                        $display("%0t: result_bits expected %h actual %h",
                                 $time, want.bits, o_result_bits);
                        errors++;
                    end
                    if (o_is_best !== want.best) begin
                        $display("%0t: is_best expected %b actual %b",
                                 $time, want.best, o_is_best);
                        errors++;
                    end
                    if (o_last !== want.last) begin
                        $display("%0t: last expected %b actual %b",
                                 $time, want.last, o_last);
                        errors++;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_request(t_request rq);
        int gap;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_req_type        <= rq.req;
        i_chromosome_bits <= rq.bits;
        i_first_index     <= rq.idx_a;
        i_second_index    <= rq.idx_b;
        i_cross_start     <= rq.seg_start;
        i_cross_stop      <= rq.seg_stop;
        i_mutate_position <= rq.flip_pos;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        evolve_population(rq);
    endtask

    // wait until every result is in and the block has settled
    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_chroms.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= addr; pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_GENES) genes_reg = data[5:0];
        else pop_reg = data[5:0];
    endtask

    function automatic t_request make_req(logic [1:0] req, logic [31:0] bits,
                                          logic [5:0] a, logic [5:0] b,
                                          logic [5:0] s, logic [5:0] e,
                                          logic [5:0] pos);
        t_request rq;
        rq.req = req; rq.bits = bits; rq.idx_a = a; rq.idx_b = b;
        rq.seg_start = s; rq.seg_stop = e; rq.flip_pos = pos;
        return rq;
    endfunction

    function automatic t_request random_noise();
        return make_req(2'($urandom_range(3)), $urandom, 6'($urandom), 6'($urandom),
                        6'($urandom), 6'($urandom), 6'($urandom));
    endfunction

    function automatic t_request random_pair();
        int unsigned g, p, a, b, s;
        g = used_genes();
        p = used_pop();
        a = $urandom_range(1, p);
        do b = $urandom_range(1, p); while (b == a);
        s = $urandom_range(1, g);
        return make_req(REQ_PAIR, $urandom, 6'(a), 6'(b), 6'(s),
                        6'($urandom_range(s, g)), 6'd0);
    endfunction

    // directed: early requests, masking, bad pair forms, mutate edges
    task automatic test_directed();
        apb_write(ADDR_GENES, 32'd8);
        apb_write(ADDR_POP, 32'd3);
        send_request(make_req(REQ_UNUSED, '1, 6'd1, 6'd2, 6'd1, 6'd8, 6'd1));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd2, 6'd1, 6'd8, 6'd0));
        send_request(make_req(REQ_MUTATE, '0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd1));
        send_request(make_req(REQ_LOAD, 32'hFFFF_FFFF, '1, '1, '1, '1, '1));
        send_request(make_req(REQ_LOAD, 32'h0000_0000, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
        send_request(make_req(REQ_LOAD, 32'h0000_0080, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
        send_request(make_req(REQ_LOAD, 32'h0000_0001, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd3, 6'd1, 6'd1, 6'd8, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd2, 6'd2, 6'd1, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd0, 6'd2, 6'd1, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd4, 6'd1, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd63, 6'd1, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd2, 6'd0, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd2, 6'd5, 6'd4, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd2, 6'd4, 6'd9, 6'd0));
        send_request(make_req(REQ_PAIR, '0, 6'd1, 6'd2, 6'd4, 6'd4, 6'd0));
        send_request(make_req(REQ_MUTATE, '0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd0));
        send_request(make_req(REQ_MUTATE, '0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd8));
        send_request(make_req(REQ_MUTATE, '0, 6'd0, 6'd0, 6'd0, 6'd0, 6'd9));
        send_request(make_req(REQ_MUTATE, '1, '1, '1, '1, '1, 6'd63));
        drain();
    endtask

    // population grows past the load count, then shrinks, genes change too
    task automatic test_register_change();
        apb_write(ADDR_POP, 32'd5);
        apb_write(ADDR_GENES, 32'd12);
        send_request(random_pair());
        send_request(make_req(REQ_LOAD, $urandom, '0, '0, '0, '0, '0));
        send_request(make_req(REQ_LOAD, $urandom, '0, '0, '0, '0, '0));
        send_request(random_pair());
        send_request(make_req(REQ_MUTATE, '0, '0, '0, '0, '0, 6'd3));
        drain();
        apb_write(ADDR_POP, 32'd2);
        apb_write(ADDR_GENES, 32'd4);
        send_request(make_req(REQ_LOAD, $urandom, '0, '0, '0, '0, '0));
        send_request(random_pair());
        send_request(make_req(REQ_MUTATE, '0, '0, '0, '0, '0, 6'd4));
        drain();
    endtask

    // randomized generations over several register settings
    task automatic test_random_generations();
        int gene_set [9] = '{32, 1, 5, 16, 0, 63, 7, 24, 3};
        int pop_set  [9] = '{32, 2, 4, 6, 1, 63, 8, 3, 12};
        int idle_send [3] = '{21, 53, 0};
        int idle_recv [3] = '{53, 21, 0};
        int pick;
        t_request rq;
        for (int ph = 0; ph < 9; ph++) begin
            send_idle_pct = idle_send[ph / 3];
            recv_idle_pct = idle_recv[ph / 3];
            apb_write(ADDR_GENES, gene_set[ph]);
            apb_write(ADDR_POP, pop_set[ph]);
            while (load_count < used_pop())
                send_request(make_req(REQ_LOAD, $urandom, '0, '0, '0, '0, '0));
            for (int n = 0; n < 12; n++) begin
                pick = $urandom_range(99);
                if (pick < 65) rq = random_pair();
                else if (pick < 82) rq = make_req(REQ_MUTATE, $urandom, 6'($urandom),
                                                  6'($urandom), 6'($urandom),
                                                  6'($urandom),
                                                  6'($urandom_range(0, used_genes() + 1)));
                else rq = random_noise();
                send_request(rq);
            end
            drain();
        end
    endtask

    initial begin
        send_idle_pct = 21;
        recv_idle_pct = 53;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_register_change();
        test_random_generations();
        drain();
        if (errors == 0 && expected_chroms.size() == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gpe_pkg.sv
rtl/core/gpe_cell.sv
rtl/core/genetic_population_engine.sv
bench/testbench.sv
